@@ hdl/tsm_pkg.sv @@
package tsm_pkg;

   localparam int LIST_DEPTH  = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W       = $clog2(LIST_DEPTH + 1);

   localparam logic [1:0] CMD_PUSH_FIRST  = 2'd0;
   localparam logic [1:0] CMD_PUSH_SECOND = 2'd1;
   localparam logic [1:0] CMD_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] out_value;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic push_first;
      logic push_second;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic has_more;
      logic slot_free;
   } dp_status_type;

endpackage

@@ hdl/two_way_sorted_merge.sv @@
// Pushes are accepted back to back while no run is in progress. A run first enters the
// merge state, then emits one merged value per cycle unless the result side stalls,
// then clears the counts and returns to idle. The first value appears in the result
// register after the merge state is entered; the two list stores are single-port-read
// memories whose heads are read ahead from the next pointer values.
// Synchronous active-high reset empties both lists; store contents are not cleared.
module two_way_sorted_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsm_pkg::rsp_type rsp_payload
);

   tsm_pkg::dp_cmd_type    cmd;
   tsm_pkg::dp_status_type status;

   tsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_command(req_payload.command),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   tsm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .wr_value   (req_payload.value),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule

@@ hdl/tsm_ram.sv @@
module tsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tsm_ctrl.sv @@
module tsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_command,
   output logic                   req_stall,
   output tsm_pkg::dp_cmd_type    cmd,
   input  tsm_pkg::dp_status_type status
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic state_ff;
   logic state_in;
   logic accepted;

   assign req_stall = (state_ff != ST_IDLE);
   assign accepted  = req_valid && !req_stall;

   always_comb begin
      state_in        = state_ff;
      cmd.push_first  = 1'b0;
      cmd.push_second = 1'b0;
      cmd.step        = 1'b0;
      cmd.finish      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               case (req_command)
                  tsm_pkg::CMD_PUSH_FIRST:  cmd.push_first  = 1'b1;
                  tsm_pkg::CMD_PUSH_SECOND: cmd.push_second = 1'b1;
                  tsm_pkg::CMD_RUN:         state_in        = ST_MERGE;
                  default:                  state_in        = ST_IDLE;
               endcase
            end
         end
         ST_MERGE: begin
            // Both list heads are read ahead, so a value can leave every cycle the result slot is free.
            if (!status.has_more) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.slot_free) begin
               cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/tsm_datapath.sv @@
module tsm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tsm_pkg::dp_cmd_type                  cmd,
   output tsm_pkg::dp_status_type               status,
   input  logic signed [tsm_pkg::VALUE_WIDTH-1:0] wr_value,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output tsm_pkg::rsp_type                     rsp_payload
);

   logic [tsm_pkg::CNT_W-1:0] cnt_a_ff, cnt_a_in;
   logic [tsm_pkg::CNT_W-1:0] cnt_b_ff, cnt_b_in;
   logic [tsm_pkg::CNT_W-1:0] ptr_a_ff, ptr_a_in;
   logic [tsm_pkg::CNT_W-1:0] ptr_b_ff, ptr_b_in;
   logic                      out_valid_ff, out_valid_in;
   tsm_pkg::rsp_type          out_ff, out_in;

   logic [tsm_pkg::VALUE_WIDTH-1:0] head_a;
   logic [tsm_pkg::VALUE_WIDTH-1:0] head_b;
   logic                            wr_a;
   logic                            wr_b;
   logic                            a_has;
   logic                            b_has;
   logic                            take_a;
   logic                            is_last;
   logic [tsm_pkg::CNT_W:0]         done_sum;
   logic [tsm_pkg::CNT_W:0]         total_sum;

   assign wr_a = cmd.push_first  && (cnt_a_ff < tsm_pkg::CNT_W'(tsm_pkg::LIST_DEPTH));
   assign wr_b = cmd.push_second && (cnt_b_ff < tsm_pkg::CNT_W'(tsm_pkg::LIST_DEPTH));

   // Read addresses follow the next pointer values, so during a run the registered read
   // data are the current heads of both lists.
   tsm_ram #(
      .WIDTH(tsm_pkg::VALUE_WIDTH),
      .DEPTH(tsm_pkg::LIST_DEPTH)
   ) u_ram_a (
      .clock  (clock),
      .wr_en  (wr_a),
      .wr_addr(cnt_a_ff[tsm_pkg::ADDR_W-1:0]),
      .wr_data(wr_value),
      .rd_addr(ptr_a_in[tsm_pkg::ADDR_W-1:0]),
      .rd_data(head_a)
   );

   tsm_ram #(
      .WIDTH(tsm_pkg::VALUE_WIDTH),
      .DEPTH(tsm_pkg::LIST_DEPTH)
   ) u_ram_b (
      .clock  (clock),
      .wr_en  (wr_b),
      .wr_addr(cnt_b_ff[tsm_pkg::ADDR_W-1:0]),
      .wr_data(wr_value),
      .rd_addr(ptr_b_in[tsm_pkg::ADDR_W-1:0]),
      .rd_data(head_b)
   );

   assign a_has  = ptr_a_ff < cnt_a_ff;
   assign b_has  = ptr_b_ff < cnt_b_ff;
   // Ties go to the second list.
   assign take_a = a_has && (!b_has || ($signed(head_a) < $signed(head_b)));

   assign done_sum  = {1'b0, ptr_a_ff} + {1'b0, ptr_b_ff} + (tsm_pkg::CNT_W+1)'(1);
   assign total_sum = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign is_last   = (done_sum == total_sum);

   assign status.has_more  = a_has || b_has;
   assign status.slot_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      if (cmd.finish) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
         ptr_a_in = '0;
         ptr_b_in = '0;
      end else begin
         if (wr_a) begin
            cnt_a_in = cnt_a_ff + tsm_pkg::CNT_W'(1);
         end
         if (wr_b) begin
            cnt_b_in = cnt_b_ff + tsm_pkg::CNT_W'(1);
         end
         if (cmd.step && take_a) begin
            ptr_a_in = ptr_a_ff + tsm_pkg::CNT_W'(1);
         end
         if (cmd.step && !take_a) begin
            ptr_b_in = ptr_b_ff + tsm_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (cmd.step) begin
         out_valid_in     = 1'b1;
         out_in.out_value = take_a ? head_a : head_b;
         out_in.last      = is_last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

@@ hdl/tsm_checker.sv @@
module tsm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tsm_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tsm_pkg::rsp_type rsp_payload
);

   // A result held back by the receiver stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // A push never causes a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.command != tsm_pkg::CMD_RUN && !rsp_valid
      |=> !rsp_valid)
      else $error("result appeared after a push");

   // While a run is still being emitted no new transaction is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> req_stall)
      else $error("request accepted in the middle of a run");

endmodule

bind two_way_sorted_merge tsm_checker u_tsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_payload(req_payload),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
